// ----- rtl/core/pem_pkg.sv -----
// Shared types and constants of the Prewitt edge magnitude core.
`timescale 1ns / 1ps

package pem_pkg;

    // Pixel and configuration widths.
    localparam int PIX_W   = 8;
    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 13;
    localparam int CFG_W   = 13;

    // Default frame limits and register reset values.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    // Largest grey level; both gradients and their sum saturate here.
    localparam int PIX_MAX = 255;

    typedef logic [PIX_W-1:0] pix_t;

    // One column of the 3x3 window: oldest row on top, current row at the bottom.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } win_col_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

// ----- rtl/core/pem_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/pem_kernel.sv -----
// Prewitt gradient arithmetic over one 3x3 window.
`timescale 1ns / 1ps

module pem_kernel (
    input  pem_pkg::win_col_t left_col,
    input  pem_pkg::win_col_t mid_col,
    input  pem_pkg::win_col_t right_col,
    output pem_pkg::pix_t     edge_res
);

    import pem_pkg::*;

    localparam int SUM_W  = PIX_W + 2;
    localparam int DIFF_W = SUM_W + 1;

    logic [SUM_W-1:0]         top_sum;
    logic [SUM_W-1:0]         bot_sum;
    logic [SUM_W-1:0]         left_sum;
    logic [SUM_W-1:0]         right_sum;
    logic signed [DIFF_W-1:0] grad_v;
    logic signed [DIFF_W-1:0] grad_h;
    logic [PIX_W-1:0]         clamp_v;
    logic [PIX_W-1:0]         clamp_h;
    logic [PIX_W:0]           mag;

    // Clamp a signed gradient to the pixel range.
    function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [DIFF_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > DIFF_W'(PIX_MAX))
        begin
            res = PIX_W'(PIX_MAX);
        end
        else
        begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    // Row and column sums.
    assign top_sum   = SUM_W'(left_col.top) + SUM_W'(mid_col.top) + SUM_W'(right_col.top);
    assign bot_sum   = SUM_W'(left_col.bot) + SUM_W'(mid_col.bot) + SUM_W'(right_col.bot);
    assign left_sum  = SUM_W'(left_col.top) + SUM_W'(left_col.mid) + SUM_W'(left_col.bot);
    assign right_sum = SUM_W'(right_col.top) + SUM_W'(right_col.mid) + SUM_W'(right_col.bot);

    // Vertical and horizontal gradients.
    assign grad_v = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
    assign grad_h = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});

    assign clamp_v = clamp_pix(grad_v);
    assign clamp_h = clamp_pix(grad_h);

    // Saturating sum of the two clamped gradients.
    assign mag = {1'b0, clamp_v} + {1'b0, clamp_h};

    always_comb
    begin
        if (mag > (PIX_W + 1)'(PIX_MAX))
        begin
            edge_res = PIX_W'(PIX_MAX);
        end
        else
        begin
            edge_res = mag[PIX_W-1:0];
        end
    end

endmodule

// ----- rtl/core/prewitt_edge_magnitude_core.sv -----
// A result is offered after the pixel that completes its window leaves the line-store stage; one
// pixel per clock unless result_stall holds a result back, set by the line-store RAM (one read and
// one write per cycle). The line store is one RAM of both previous rows, read by each pixel on
// entry and written back as it leaves. Reset (rst_n, asynchronous, active low) clears the pipeline
// valids and position counters and loads width 640 and height 480; the line store is not cleared.
`timescale 1ns / 1ps

module prewitt_edge_magnitude_core #(
    parameter int MAX_WIDTH  = pem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pem_pkg::DEF_MAX_HEIGHT,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port.
    input  logic                   cfg_we,
    input  pem_pkg::cfg_index_t    cfg_index,
    input  logic [pem_pkg::CFG_W-1:0] cfg_data,
    // Pixel input channel.
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  pem_pkg::pix_t          pixel,
    // Result output channel.
    output logic                   result_valid,
    input  logic                   result_stall,
    output pem_pkg::pix_t          edge_res,
    output logic [ROW_W-1:0]       center_row,
    output logic [COL_W-1:0]       center_col,
    output logic                   last_of_frame
);

    import pem_pkg::*;

    localparam int WL_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
    localparam int HL_W = (ROW_W + 1 > IMG_H_W) ? ROW_W + 1 : IMG_H_W;

    // Configuration registers.
    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_W_W-1:0] image_width_next;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [IMG_H_W-1:0] image_height_next;

    // Position of the next pixel.
    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;

    // Frame bounds in use.
    logic [WL_W-1:0] width_cfg;
    logic [WL_W-1:0] width_eff;
    logic [WL_W-1:0] width_last;
    logic [HL_W-1:0] height_cfg;
    logic [HL_W-1:0] height_eff;
    logic [HL_W-1:0] height_last;
    logic            col_at_end;
    logic            row_at_end;
    logic            pixel_xfer;
    logic            interior;

    // Line-store stage.
    logic             s1_valid_reg;
    logic             s1_valid_next;
    pix_t             s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_produce_reg;
    logic             s1_last_reg;
    logic             s1_adv;
    logic [2*PIX_W-1:0] line_rdata;
    win_col_t         new_col;

    // Window columns left over from the previous two pixels.
    win_col_t win_c1_reg;
    win_col_t win_c2_reg;
    pix_t     kernel_res;

    // Result register.
    logic             result_valid_reg;
    logic             result_valid_next;
    logic             out_free;
    pix_t             edge_res_reg;
    logic [ROW_W-1:0] center_row_reg;
    logic [COL_W-1:0] center_col_reg;
    logic             last_reg;

    // Clamp the configured frame size to the supported range.
    always_comb
    begin
        width_cfg  = WL_W'(image_width_reg);
        height_cfg = HL_W'(image_height_reg);
        if (width_cfg < WL_W'(3))
        begin
            width_eff = WL_W'(3);
        end
        else if (width_cfg > WL_W'(MAX_WIDTH))
        begin
            width_eff = WL_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_cfg;
        end
        if (height_cfg < HL_W'(3))
        begin
            height_eff = HL_W'(3);
        end
        else if (height_cfg > HL_W'(MAX_HEIGHT))
        begin
            height_eff = HL_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_cfg;
        end
        width_last  = width_eff - WL_W'(1);
        height_last = height_eff - HL_W'(1);
    end

    assign col_at_end = WL_W'(col_count_reg) >= width_last;
    assign row_at_end = HL_W'(row_count_reg) >= height_last;
    assign interior   = (row_count_reg >= ROW_W'(2)) && (col_count_reg >= COL_W'(2));

    // Handshake: the line-store stage moves on unless its result cannot be placed.
    assign out_free    = !result_valid_reg || !result_stall;
    assign s1_adv      = s1_valid_reg && (!s1_produce_reg || out_free);
    assign pixel_stall = s1_valid_reg && !s1_adv;
    assign pixel_xfer  = pixel_valid && !pixel_stall;

    // Configuration writes and position counters; a write restarts the frame.
    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        col_count_next    = col_count_reg;
        row_count_next    = row_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_next = cfg_data[IMG_H_W-1:0];
                default:          image_width_next  = image_width_reg;
            endcase
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (pixel_xfer)
        begin
            if (col_at_end)
            begin
                col_count_next = '0;
                row_count_next = row_at_end ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_W_W'(RESET_WIDTH);
            image_height_reg <= IMG_H_W'(RESET_HEIGHT);
            col_count_reg    <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            col_count_reg    <= col_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // Line store: upper row in the high byte, lower row in the low byte.
    pem_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({line_rdata[PIX_W-1:0], s1_pix_reg}),
        .re    (pixel_xfer),
        .raddr (col_count_reg),
        .rdata (line_rdata)
    );

    // Line-store stage control.
    always_comb
    begin
        if (pixel_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Line-store stage payload.
    always_ff @(posedge clk)
    begin
        if (pixel_xfer)
        begin
            s1_pix_reg     <= pixel;
            s1_col_reg     <= col_count_reg;
            s1_row_reg     <= row_count_reg;
            s1_produce_reg <= interior;
            s1_last_reg    <= col_at_end && row_at_end;
        end
    end

    // Newest window column: two rows up, one row up, current pixel.
    assign new_col.top = line_rdata[2*PIX_W-1:PIX_W];
    assign new_col.mid = line_rdata[PIX_W-1:0];
    assign new_col.bot = s1_pix_reg;

    // Window shift.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_c1_reg <= win_c2_reg;
            win_c2_reg <= new_col;
        end
    end

    pem_kernel u_kernel (
        .left_col  (win_c1_reg),
        .mid_col   (win_c2_reg),
        .right_col (new_col),
        .edge_res  (kernel_res)
    );

    // Result register control.
    always_comb
    begin
        if (s1_adv && s1_produce_reg)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_produce_reg)
        begin
            edge_res_reg   <= kernel_res;
            center_row_reg <= s1_row_reg - ROW_W'(1);
            center_col_reg <= s1_col_reg - COL_W'(1);
            last_reg       <= s1_last_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign edge_res      = edge_res_reg;
    assign center_row    = center_row_reg;
    assign center_col    = center_col_reg;
    assign last_of_frame = last_reg;

`ifndef NO_ASSERTIONS
    // The column counter never runs past the last column of the frame.
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WL_W'(col_count_reg) <= width_last)
        else $error("column counter beyond frame width");

    // A configuration write restarts the frame at the first pixel.
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (col_count_reg == '0) && (row_count_reg == '0))
        else $error("frame position not cleared by configuration write");

    // The input is held back only while a result is waiting for the output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> s1_valid_reg && s1_produce_reg && result_valid_reg && result_stall)
        else $error("pixel stalled without a blocked result");

    // A result always refers to an interior window center.
    a_center_interior: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (center_row != '0) && (center_col != '0))
        else $error("result at a border position");
`endif

endmodule
